// ===== rtl/iorc_pkg.sv =====
package iorc_pkg;

  // Request kinds as they appear in io_kind.
  localparam logic [2:0] KindInvalid = 3'd0;
  localparam logic [2:0] KindRead    = 3'd1;
  localparam logic [2:0] KindWrite   = 3'd2;
  localparam logic [2:0] KindFsync   = 3'd3;
  localparam logic [2:0] KindFlush   = 3'd4;
  localparam logic [2:0] KindNop     = 3'd5;

  // Configuration register indexes.
  localparam logic CfgScatterGather = 1'b0;
  localparam logic CfgMaxRunLength  = 1'b1;

  localparam logic [6:0] MaxRunLengthReset = 7'd16;
  localparam logic [6:0] RunCountReset     = 7'd1;

  typedef struct packed {
    logic        batch_start;
    logic [2:0]  io_kind;
    logic [7:0]  callback_id;
    logic        retry_marked;
    logic [15:0] file_id;
    logic [63:0] file_offset;
    logic [31:0] byte_count;
    logic [47:0] buffer_address;
  } req_t;

  typedef struct packed {
    logic       merge_with_previous;
    logic [6:0] run_position;
    logic       invalid_kind;
  } rsp_t;

  typedef struct packed {
    logic        scatter_gather_enabled;
    logic [6:0]  max_run_length;
  } cfg_t;

  typedef struct packed {
    logic        have_previous;
    logic [2:0]  prev_kind;
    logic [7:0]  prev_callback;
    logic        prev_retry;
    logic [15:0] prev_file;
    logic [63:0] prev_end_offset;
    logic [47:0] prev_end_buffer;
    logic [6:0]  run_count;
  } state_t;

endpackage

// ===== rtl/iorc_req_if.sv =====
interface iorc_req_if;
  logic        valid;
  logic        ready;
  logic        batch_start;
  logic [2:0]  io_kind;
  logic [7:0]  callback_id;
  logic        retry_marked;
  logic [15:0] file_id;
  logic [63:0] file_offset;
  logic [31:0] byte_count;
  logic [47:0] buffer_address;

  modport source (
    output valid, batch_start, io_kind, callback_id, retry_marked, file_id,
           file_offset, byte_count, buffer_address,
    input  ready
  );

  modport sink (
    input  valid, batch_start, io_kind, callback_id, retry_marked, file_id,
           file_offset, byte_count, buffer_address,
    output ready
  );
endinterface

// ===== rtl/iorc_rsp_if.sv =====
interface iorc_rsp_if;
  logic       valid;
  logic       ready;
  logic       merge_with_previous;
  logic [6:0] run_position;
  logic       invalid_kind;

  modport source (
    output valid, merge_with_previous, run_position, invalid_kind,
    input  ready
  );

  modport sink (
    input  valid, merge_with_previous, run_position, invalid_kind,
    output ready
  );
endinterface

// ===== rtl/iorc_decide.sv =====
module iorc_decide (
  input  iorc_pkg::req_t   req_i,
  input  iorc_pkg::state_t state_i,
  input  iorc_pkg::cfg_t   cfg_i,
  output iorc_pkg::rsp_t   rsp_o,
  output iorc_pkg::state_t state_o
);
  import iorc_pkg::*;

  logic       have_prev;
  logic       same_stream;
  logic       rw_kind;
  logic       bad_kind;
  logic       merge_ok;
  logic [6:0] count;
  logic       cut;

  assign have_prev   = state_i.have_previous && !req_i.batch_start;
  assign same_stream = (state_i.prev_kind == req_i.io_kind) &&
                       (state_i.prev_callback == req_i.callback_id) &&
                       !state_i.prev_retry && !req_i.retry_marked;
  assign rw_kind     = (req_i.io_kind == KindRead) || (req_i.io_kind == KindWrite);
  // Codes above the last defined kind count as invalid too.
  assign bad_kind    = (req_i.io_kind == KindInvalid) || (req_i.io_kind > KindNop);

  assign merge_ok = have_prev && same_stream && rw_kind &&
                    (state_i.prev_file == req_i.file_id) &&
                    (state_i.prev_end_offset == req_i.file_offset) &&
                    (cfg_i.scatter_gather_enabled ||
                     (state_i.prev_end_buffer == req_i.buffer_address));

  assign count = merge_ok ? state_i.run_count + 7'd1 : RunCountReset;
  // A request with no previous one to compare against is never cut.
  assign cut   = have_prev && (count >= cfg_i.max_run_length);

  always_comb begin
    rsp_o.merge_with_previous = merge_ok;
    rsp_o.run_position        = count;
    rsp_o.invalid_kind        = have_prev && same_stream && bad_kind;

    state_o = state_i;
    if (cut) begin
      state_o.have_previous = 1'b0;
      state_o.run_count     = RunCountReset;
    end else begin
      state_o.have_previous   = 1'b1;
      state_o.run_count       = count;
      state_o.prev_kind       = req_i.io_kind;
      state_o.prev_callback   = req_i.callback_id;
      state_o.prev_retry      = req_i.retry_marked;
      state_o.prev_file       = req_i.file_id;
      state_o.prev_end_offset = req_i.file_offset + {32'd0, req_i.byte_count};
      state_o.prev_end_buffer = req_i.buffer_address + {16'd0, req_i.byte_count};
    end
  end
endmodule

// ===== rtl/io_request_coalescer_core.sv =====
// Back-merge decision for a stream of pending IO requests. Each request item
// yields one result item telling whether it joins the run of the request
// before it, its position in that run, and whether an invalid kind was met in
// the stream of the previous request. An item is registered at the input,
// decided by one pass of compare and add logic against the stored previous
// request, and the result is registered at the output; the block takes one
// item per cycle while the output is not stalled. While a result waits, one
// more item can still be taken into the input register; after that the input
// stalls until the result is taken. Configuration registers (index 0:
// scatter-gather enable, index 1: maximum run length) are written through
// cfg_we_i and should change only while the block is idle.
module io_request_coalescer_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_idx_i,
  input  logic [6:0]      cfg_data_i,
  iorc_req_if.sink        req_i,
  iorc_rsp_if.source      rsp_o
);
  import iorc_pkg::*;

  cfg_t   cfg_q;
  state_t state_q, state_d;
  req_t   s0_q, req_in;
  logic   s0_valid_q;
  rsp_t   rsp_q, rsp_d;
  logic   rsp_valid_q;
  logic   advance;

  assign req_in = '{
    batch_start:    req_i.batch_start,
    io_kind:        req_i.io_kind,
    callback_id:    req_i.callback_id,
    retry_marked:   req_i.retry_marked,
    file_id:        req_i.file_id,
    file_offset:    req_i.file_offset,
    byte_count:     req_i.byte_count,
    buffer_address: req_i.buffer_address
  };

  // The decided item moves to the output when the output register is free.
  assign advance     = s0_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s0_valid_q || advance;

  iorc_decide u_decide (
    .req_i   (s0_q),
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .rsp_o   (rsp_d),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{scatter_gather_enabled: 1'b0, max_run_length: MaxRunLengthReset};
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgScatterGather: cfg_q.scatter_gather_enabled <= cfg_data_i[0];
        CfgMaxRunLength:  cfg_q.max_run_length         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{
        have_previous:   1'b0,
        prev_kind:       KindInvalid,
        prev_callback:   8'd0,
        prev_retry:      1'b0,
        prev_file:       16'd0,
        prev_end_offset: 64'd0,
        prev_end_buffer: 48'd0,
        run_count:       RunCountReset
      };
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s0_valid_q <= req_i.valid;
      end
      if (advance) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s0_q <= req_in;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid               = rsp_valid_q;
  assign rsp_o.merge_with_previous = rsp_q.merge_with_previous;
  assign rsp_o.run_position        = rsp_q.run_position;
  assign rsp_o.invalid_kind        = rsp_q.invalid_kind;
endmodule
